// ===== rtl/draw_strip_splitter_core_macros.svh =====
// Assertion helpers for the splitter core RTL.
`ifndef DRAW_STRIP_SPLITTER_CORE_MACROS_SVH
`define DRAW_STRIP_SPLITTER_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dss_pkg.sv =====
`default_nettype none

package dss_pkg;

   localparam int OFFSET_W  = 24;
   localparam int OUT_W     = 24;
   localparam int MV_W      = 16;
   localparam int STRIDE_W  = 10;
   localparam int PTYPE_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = MV_W;

   localparam int INDEX_WIDTH_DEFAULT = 24;
   localparam int MAX_CHUNKS_DEFAULT  = 63;

   localparam logic [PTYPE_W-1:0] PRIM_POINTS     = 4'd0;
   localparam logic [PTYPE_W-1:0] PRIM_LINES      = 4'd1;
   localparam logic [PTYPE_W-1:0] PRIM_LINE_LOOP  = 4'd2;
   localparam logic [PTYPE_W-1:0] PRIM_LINE_STRIP = 4'd3;
   localparam logic [PTYPE_W-1:0] PRIM_TRIANGLES  = 4'd4;
   localparam logic [PTYPE_W-1:0] PRIM_TRI_STRIP  = 4'd5;
   localparam logic [PTYPE_W-1:0] PRIM_FAN        = 4'd6;
   localparam logic [PTYPE_W-1:0] PRIM_QUADS      = 4'd7;
   localparam logic [PTYPE_W-1:0] PRIM_QUAD_STRIP = 4'd8;
   localparam logic [PTYPE_W-1:0] PRIM_POLYGON    = 4'd9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRIMITIVE_TYPE   = 2'd0,
      CSR_MAX_VERTICES     = 2'd1,
      CSR_VERTEX_STRIDE    = 2'd2,
      CSR_THRESHOLD_SELECT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PTYPE_W-1:0]  primitive_type;
      logic [MV_W-1:0]     max_vertices;
      logic [STRIDE_W-1:0] vertex_stride;
      logic                threshold_select;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      primitive_type:   PRIM_TRIANGLES,
      max_vertices:     16'd1024,
      vertex_stride:    10'd12,
      threshold_select: 1'b0
   };

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   function automatic int div_width(int index_width);
      return (index_width > OFFSET_W) ? index_width : OFFSET_W;
   endfunction

   function automatic logic [2:0] restart_multiple(logic [PTYPE_W-1:0] t);
      logic [2:0] r;
      case (t)
         PRIM_LINES, PRIM_TRI_STRIP, PRIM_QUAD_STRIP: r = 3'd2;
         PRIM_TRIANGLES: r = 3'd3;
         PRIM_QUADS:     r = 3'd4;
         default:        r = 3'd1;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] chunk_overlap(logic [PTYPE_W-1:0] t);
      logic [1:0] r;
      case (t)
         PRIM_TRI_STRIP, PRIM_QUAD_STRIP: r = 2'd2;
         PRIM_LINE_STRIP: r = 2'd1;
         default:         r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic is_splitable(logic [PTYPE_W-1:0] t);
      logic r;
      case (t)
         PRIM_LINE_LOOP, PRIM_FAN, PRIM_POLYGON: r = 1'b0;
         default: r = 1'b1;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/dss_req_if.sv =====
`default_nettype none

interface dss_req_if;
   import dss_pkg::*;

   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] strip_end_offset;
   logic                batch_last;

   modport source (output valid, output strip_end_offset, output batch_last, input ready);
   modport sink   (input valid, input strip_end_offset, input batch_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/dss_rsp_if.sv =====
`default_nettype none

interface dss_rsp_if;
   import dss_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] first_vertex;
   logic [OUT_W-1:0] vertex_count;
   logic             strip_begin;
   logic             range_last;

   modport source (output valid, output first_vertex, output vertex_count,
                   output strip_begin, output range_last, input ready);
   modport sink   (input valid, input first_vertex, input vertex_count,
                   input strip_begin, input range_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/dss_divider.sv =====
`default_nettype none

module dss_divider #(
   parameter int DIV_WIDTH = dss_pkg::div_width(dss_pkg::INDEX_WIDTH_DEFAULT)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dss_pkg::div_ctl_type      ctl,
   input  wire logic [DIV_WIDTH-1:0]      dividend,
   input  wire logic [dss_pkg::MV_W-1:0]  divisor,
   output dss_pkg::div_sts_type           sts,
   output logic      [DIV_WIDTH-1:0]      quotient,
   output logic      [dss_pkg::MV_W-1:0]  remainder
);
   import dss_pkg::*;

   localparam int CW = $clog2(DIV_WIDTH + 1);

   logic [DIV_WIDTH-1:0] quo_ff, quo_in;
   logic [MV_W-1:0]      rem_ff, rem_in;
   logic [MV_W-1:0]      dvs_ff, dvs_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   logic [MV_W:0] shifted;
   logic [MV_W:0] diff;

   assign shifted = {rem_ff, quo_ff[DIV_WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CW'(DIV_WIDTH);
      end else if (cnt_ff != '0) begin
         // restoring step: one quotient bit a cycle
         if (!diff[MV_W]) begin
            rem_in = diff[MV_W-1:0];
            quo_in = {quo_ff[DIV_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[MV_W-1:0];
            quo_in = {quo_ff[DIV_WIDTH-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts       = '{busy: (cnt_ff != '0), done: done_ff};
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/dss_sequencer.sv =====
`default_nettype none

module dss_sequencer #(
   parameter int INDEX_WIDTH = dss_pkg::INDEX_WIDTH_DEFAULT,
   parameter int MAX_CHUNKS  = dss_pkg::MAX_CHUNKS_DEFAULT
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire dss_pkg::cfg_type                          cfg,
   input  wire logic                                      req_valid,
   output logic                                           req_ready,
   input  wire logic [dss_pkg::OFFSET_W-1:0]              req_offset,
   input  wire logic                                      req_last,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_ready,
   output logic      [dss_pkg::OUT_W-1:0]                 rsp_first,
   output logic      [dss_pkg::OUT_W-1:0]                 rsp_count,
   output logic                                           rsp_begin,
   output logic                                           rsp_last,
   output dss_pkg::div_ctl_type                           div_ctl,
   input  wire dss_pkg::div_sts_type                      div_sts,
   output logic      [dss_pkg::div_width(INDEX_WIDTH)-1:0] div_dividend,
   output logic      [dss_pkg::MV_W-1:0]                  div_divisor,
   input  wire logic [dss_pkg::div_width(INDEX_WIDTH)-1:0] div_quotient,
   input  wire logic [dss_pkg::MV_W-1:0]                  div_remainder
);
   import dss_pkg::*;

   localparam int IW  = INDEX_WIDTH;
   localparam int DW  = div_width(INDEX_WIDTH);
   localparam int PCW = $clog2(MAX_CHUNKS + 1);
   localparam int TW  = IW + 3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_END,
      S_DIV_CHUNK,
      S_DECIDE,
      S_DIV_PIECES,
      S_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [IW-1:0]    start_ff, start_in;
   logic [IW-1:0]    base_ff, base_in;
   logic [IW-1:0]    length_ff, length_in;
   logic             batch_ff, batch_in;
   logic [MV_W-1:0]  chunk_ff, chunk_in;
   logic [PCW-1:0]   pieces_ff, pieces_in;
   logic [PCW-1:0]   idx_ff, idx_in;
   logic [IW-1:0]    cursor_ff, cursor_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] first_ff, first_in;
   logic [OUT_W-1:0] count_ff, count_in;
   logic             begin_ff, begin_in;
   logic             rlast_ff, rlast_in;

   logic [IW-1:0]       end_idx;
   logic [2:0]          rmul;
   logic [1:0]          ovl;
   logic [STRIDE_W-1:0] stride_eff;
   logic [TW-1:0]       len_scaled;
   logic [TW-1:0]       chunk_scaled;
   logic                over;
   logic                split;
   logic [PCW-1:0]      pieces_sat;
   logic [IW-1:0]       first_at_cursor;
   logic [IW-1:0]       cursor_next;
   logic [IW-1:0]       rest_count;
   logic [DW-1:0]       first_wide;
   logic [DW-1:0]       chunk_wide;
   logic [DW-1:0]       rest_wide;
   logic                more_after;

   assign end_idx    = div_quotient[IW-1:0];
   assign rmul       = restart_multiple(cfg.primitive_type);
   assign ovl        = chunk_overlap(cfg.primitive_type);
   assign stride_eff = (cfg.vertex_stride == '0) ? STRIDE_W'(1) : cfg.vertex_stride;

   always_comb begin
      if (cfg.threshold_select) begin
         len_scaled   = TW'(length_ff) << 2;
         chunk_scaled = (TW'(chunk_ff) << 2) + TW'(chunk_ff);
      end else begin
         len_scaled   = TW'(length_ff) << 1;
         chunk_scaled = (TW'(chunk_ff) << 1) + TW'(chunk_ff);
      end
   end

   assign over  = len_scaled > chunk_scaled;
   assign split = is_splitable(cfg.primitive_type) && (chunk_ff > MV_W'(ovl)) && over;

   assign pieces_sat = (div_quotient > DW'(MAX_CHUNKS)) ? PCW'(MAX_CHUNKS)
                                                        : div_quotient[PCW-1:0];

   assign first_at_cursor = base_ff + cursor_ff;
   assign cursor_next     = cursor_ff + IW'(chunk_ff) - IW'(ovl);
   assign rest_count      = length_ff - cursor_ff;
   assign first_wide      = DW'(first_at_cursor);
   assign chunk_wide      = DW'(chunk_ff);
   assign rest_wide       = DW'(rest_count);
   assign more_after      = length_ff > cursor_next;

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      base_in      = base_ff;
      length_in    = length_ff;
      batch_in     = batch_ff;
      chunk_in     = chunk_ff;
      pieces_in    = pieces_ff;
      idx_in       = idx_ff;
      cursor_in    = cursor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      first_in     = first_ff;
      count_in     = count_ff;
      begin_in     = begin_ff;
      rlast_in     = rlast_ff;
      div_ctl.start = 1'b0;
      div_dividend  = '0;
      div_divisor   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               div_ctl.start = 1'b1;
               div_dividend  = DW'(req_offset);
               div_divisor   = MV_W'(stride_eff);
               batch_in      = req_last;
               state_in      = S_DIV_END;
            end
         end
         S_DIV_END: begin
            if (div_sts.done) begin
               length_in     = end_idx - start_ff;
               base_in       = start_ff;
               start_in      = batch_ff ? '0 : end_idx;
               div_ctl.start = 1'b1;
               div_dividend  = DW'(cfg.max_vertices);
               div_divisor   = MV_W'(rmul);
               state_in      = S_DIV_CHUNK;
            end
         end
         S_DIV_CHUNK: begin
            if (div_sts.done) begin
               chunk_in = cfg.max_vertices - div_remainder;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            idx_in    = '0;
            cursor_in = '0;
            pieces_in = '0;
            if (split) begin
               div_ctl.start = 1'b1;
               div_dividend  = DW'(length_ff);
               div_divisor   = chunk_ff;
               state_in      = S_DIV_PIECES;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_DIV_PIECES: begin
            if (div_sts.done) begin
               pieces_in = pieces_sat;
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               first_in     = first_wide[OUT_W-1:0];
               begin_in     = (idx_ff == '0);
               if (idx_ff < pieces_ff) begin
                  count_in  = chunk_wide[OUT_W-1:0];
                  rlast_in  = ((idx_ff + PCW'(1)) == pieces_ff) && !more_after;
                  idx_in    = idx_ff + PCW'(1);
                  cursor_in = cursor_next;
                  if (rlast_in) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  // remainder, or the whole strip when not split
                  count_in = rest_wide[OUT_W-1:0];
                  rlast_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff   <= base_in;
      length_ff <= length_in;
      batch_ff  <= batch_in;
      chunk_ff  <= chunk_in;
      pieces_ff <= pieces_in;
      idx_ff    <= idx_in;
      cursor_ff <= cursor_in;
      first_ff  <= first_in;
      count_ff  <= count_in;
      begin_ff  <= begin_in;
      rlast_ff  <= rlast_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_first = first_ff;
   assign rsp_count = count_ff;
   assign rsp_begin = begin_ff;
   assign rsp_last  = rlast_ff;

endmodule

`default_nettype wire

// ===== rtl/draw_strip_splitter_core.sv =====
// Channel   Dir  Handshake      Payload
// req_ch    in   valid/ready    strip_end_offset, batch_last
// rsp_ch    out  valid/ready    first_vertex, vertex_count, strip_begin, range_last
// csr_*     in   write enable   csr_index, csr_write_data
//
// A strip runs the end-vertex and chunk-size divisions, plus the chunk-count one
// when split, before its first range, then one range a cycle unless rsp_ch stalls;
// the three share one bit-serial divider of max(INDEX_WIDTH, 24) bits.
// Synchronous reset idles the sequencer and divider and clears the start index.
// A stalled rsp_ch holds the range register; the next strip is taken while the
// last range of the previous one still waits.
`default_nettype none
`include "draw_strip_splitter_core_macros.svh"

module draw_strip_splitter_core #(
   parameter int INDEX_WIDTH = dss_pkg::INDEX_WIDTH_DEFAULT,
   parameter int MAX_CHUNKS  = dss_pkg::MAX_CHUNKS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   dss_req_if.sink                               req_ch,
   dss_rsp_if.source                             rsp_ch,
   input  wire logic                             csr_write_enable,
   input  wire logic [dss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dss_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import dss_pkg::*;

   localparam int DW = div_width(INDEX_WIDTH);

   cfg_type cfg_ff, cfg_in;

   div_ctl_type     div_ctl;
   div_sts_type     div_sts;
   logic [DW-1:0]   div_dividend;
   logic [MV_W-1:0] div_divisor;
   logic [DW-1:0]   div_quotient;
   logic [MV_W-1:0] div_remainder;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PRIMITIVE_TYPE:   cfg_in.primitive_type   = csr_write_data[PTYPE_W-1:0];
            CSR_MAX_VERTICES:     cfg_in.max_vertices     = csr_write_data[MV_W-1:0];
            CSR_VERTEX_STRIDE:    cfg_in.vertex_stride    = csr_write_data[STRIDE_W-1:0];
            CSR_THRESHOLD_SELECT: cfg_in.threshold_select = csr_write_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dss_sequencer #(
      .INDEX_WIDTH (INDEX_WIDTH),
      .MAX_CHUNKS  (MAX_CHUNKS)
   ) u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_offset    (req_ch.strip_end_offset),
      .req_last      (req_ch.batch_last),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_first     (rsp_ch.first_vertex),
      .rsp_count     (rsp_ch.vertex_count),
      .rsp_begin     (rsp_ch.strip_begin),
      .rsp_last      (rsp_ch.range_last),
      .div_ctl       (div_ctl),
      .div_sts       (div_sts),
      .div_dividend  (div_dividend),
      .div_divisor   (div_divisor),
      .div_quotient  (div_quotient),
      .div_remainder (div_remainder)
   );

   dss_divider #(
      .DIV_WIDTH (DW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .sts       (div_sts),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   `DSS_ASSERT_NEXT(a_accept_closes_input, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "input still open after a transfer")
   `DSS_ASSERT_SAME(a_divider_busy_blocks, clock, reset, div_sts.busy, !req_ch.ready, "input open while the divider runs")
   `DSS_ASSERT_SAME(a_mid_strip_blocks, clock, reset, rsp_ch.valid && !rsp_ch.range_last, !req_ch.ready, "input open before the last range of a strip")

endmodule

`default_nettype wire
